// ===== sv/efs_pkg.sv =====
`default_nettype none

package efs_pkg;

    localparam int ALU_W = 72;
    localparam int OPB_W = 36;

    localparam logic [1:0] ALU_MUL  = 2'd0;
    localparam logic [1:0] ALU_DIV  = 2'd1;
    localparam logic [1:0] ALU_SQRT = 2'd2;

    localparam logic [6:0] MUL_STEPS  = 7'd36;
    localparam logic [6:0] DIV_STEPS  = 7'd64;
    localparam logic [6:0] SQRT_STEPS = 7'd36;

    localparam logic [1:0] ACT_LEAVE = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_SET   = 2'd2;

    localparam logic KIND_QUERY  = 1'b0;
    localparam logic KIND_ENTITY = 1'b1;

    localparam int          PADDR_W      = 3;
    localparam logic        REG_SNAP_TOL = 1'b0;
    localparam logic [30:0] TOL_RESET    = 31'd65536;

    typedef struct packed {
        logic             start;
        logic [1:0]       op;
        logic [ALU_W-1:0] a;
        logic [OPB_W-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic             done;
        logic [ALU_W-1:0] res;
    } alu_rsp_t;

endpackage

`default_nettype wire

// ===== sv/efs_item_if.sv =====
`default_nettype none

interface efs_item_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] pointer_x;
    logic [31:0] pointer_y;
    logic [31:0] pointer_z;
    logic        is_ellipse;
    logic [31:0] right_focus_x;
    logic [31:0] right_focus_y;
    logic [31:0] left_focus_x;
    logic [31:0] left_focus_y;
    logic [30:0] focal_sum;

    modport source (
        output valid, kind, pointer_x, pointer_y, pointer_z, is_ellipse,
               right_focus_x, right_focus_y, left_focus_x, left_focus_y, focal_sum,
        input  ready
    );
    modport sink (
        input  valid, kind, pointer_x, pointer_y, pointer_z, is_ellipse,
               right_focus_x, right_focus_y, left_focus_x, left_focus_y, focal_sum,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/efs_result_if.sv =====
`default_nettype none

interface efs_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  highlight_action;
    logic        snapped;
    logic [31:0] snap_x;
    logic [31:0] snap_y;
    logic [31:0] snap_z;
    logic [9:0]  entity_index;

    modport source (
        output valid, highlight_action, snapped, snap_x, snap_y, snap_z, entity_index,
        input  ready
    );
    modport sink (
        input  valid, highlight_action, snapped, snap_x, snap_y, snap_z, entity_index,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/efs_alu.sv =====
`default_nettype none

module efs_alu
    import efs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire alu_req_t req,
    output alu_rsp_t      rsp
);

    logic             busy_reg;
    logic             done_reg;
    logic             neg_reg;
    logic [1:0]       op_reg;
    logic [6:0]       cnt_reg;
    logic [ALU_W-1:0] p_reg;
    logic [ALU_W-1:0] q_reg;
    logic [OPB_W-1:0] m_reg;

    logic [ALU_W-1:0] a_mag;
    logic [OPB_W-1:0] b_mag;
    logic [36:0]      div_r;
    logic [36:0]      div_d;
    logic [39:0]      sq_r;
    logic [39:0]      sq_t;
    logic [ALU_W-1:0] quo;
    logic             load;

    assign load  = req.start && !busy_reg;
    assign a_mag = req.a[ALU_W-1] ? ALU_W'(-req.a) : req.a;
    assign b_mag = req.b[OPB_W-1] ? OPB_W'(-req.b) : req.b;
    assign div_r = {p_reg[35:0], q_reg[63]};
    assign div_d = {1'b0, m_reg};
    assign sq_r  = {p_reg[37:0], q_reg[71:70]};
    assign sq_t  = {2'b00, m_reg, 2'b01};
    assign quo   = {8'b0, q_reg[63:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (load)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && cnt_reg == 7'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_reg  <= req.op;
            neg_reg <= req.a[ALU_W-1] ^ req.b[OPB_W-1];
            p_reg   <= '0;
            unique case (req.op)
                ALU_MUL:
                begin
                    cnt_reg <= MUL_STEPS;
                    q_reg   <= {36'b0, a_mag[35:0]};
                    m_reg   <= b_mag;
                end
                ALU_DIV:
                begin
                    cnt_reg <= DIV_STEPS;
                    q_reg   <= {8'b0, a_mag[63:0]};
                    m_reg   <= b_mag;
                end
                ALU_SQRT:
                begin
                    cnt_reg <= SQRT_STEPS;
                    q_reg   <= req.a;
                    m_reg   <= '0;
                end
                default:
                begin
                    cnt_reg <= 7'd1;
                    q_reg   <= '0;
                    m_reg   <= '0;
                end
            endcase
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 7'd1;
            unique case (op_reg)
                ALU_MUL:
                begin
                    if (m_reg[0])
                    begin
                        p_reg <= p_reg + q_reg;
                    end
                    q_reg <= {q_reg[70:0], 1'b0};
                    m_reg <= {1'b0, m_reg[35:1]};
                end
                ALU_DIV:
                begin
                    if (div_r >= div_d)
                    begin
                        p_reg <= {35'b0, div_r - div_d};
                        q_reg <= {q_reg[70:0], 1'b1};
                    end
                    else
                    begin
                        p_reg <= {35'b0, div_r};
                        q_reg <= {q_reg[70:0], 1'b0};
                    end
                end
                ALU_SQRT:
                begin
                    if (sq_r >= sq_t)
                    begin
                        p_reg <= {32'b0, sq_r - sq_t};
                        m_reg <= {m_reg[34:0], 1'b1};
                    end
                    else
                    begin
                        p_reg <= {32'b0, sq_r};
                        m_reg <= {m_reg[34:0], 1'b0};
                    end
                    q_reg <= {q_reg[69:0], 2'b00};
                end
                default:
                begin
                    p_reg <= p_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        rsp.done = done_reg;
        unique case (op_reg)
            ALU_MUL:  rsp.res = neg_reg ? ALU_W'(-p_reg) : p_reg;
            ALU_DIV:  rsp.res = neg_reg ? ALU_W'(-quo) : quo;
            ALU_SQRT: rsp.res = {36'b0, m_reg};
            default:  rsp.res = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/efs_cfg.sv =====
`default_nettype none

module efs_cfg
    import efs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    output logic      [30:0]        tol
);

    logic [30:0] tol_reg;
    logic        hit;

    assign hit    = (paddr[2] == REG_SNAP_TOL);
    assign pready = 1'b1;
    assign prdata = hit ? {1'b0, tol_reg} : '0;
    assign tol    = tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (psel && penable && pwrite && hit)
        begin
            tol_reg <= pwdata[30:0];
        end
    end

endmodule

`default_nettype wire

// ===== sv/ellipse_focal_snap.sv =====
// channel  | dir | handshake     | word
// item     | in  | valid / ready | query (pointer) or entity (foci, focal sum)
// result   | out | valid / ready | highlight action, snap point, entity index
// apb      | in  | psel/penable  | snap_tolerance at byte address 0
//
// a query word sets the query point and restarts the scan; a non-ellipse or skipped entity goes straight to S_FIN
// an ellipse runs 6 to 27 ops on the shared multiply/divide/sqrt unit
// item.ready is high only while the sequencer is idle
// the result register holds its word under result stall while the next item is taken
// reset clears the query point, scan state, counter and tolerance (1.0)
`default_nettype none

module ellipse_focal_snap
    import efs_pkg::*;
#(
    parameter int MAX_ENTITIES = 1024
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    efs_item_if.sink                item,
    efs_result_if.source            result,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready
);

    localparam int             CW      = $clog2(MAX_ENTITIES + 1);
    localparam logic [CW-1:0]  CNT_MAX = CW'(MAX_ENTITIES);

    localparam logic [5:0] S_IDLE = 6'd0;
    localparam logic [5:0] S_DRX  = 6'd1;
    localparam logic [5:0] S_DRY  = 6'd2;
    localparam logic [5:0] S_QDR  = 6'd3;
    localparam logic [5:0] S_DLX  = 6'd4;
    localparam logic [5:0] S_DLY  = 6'd5;
    localparam logic [5:0] S_QDL  = 6'd6;
    localparam logic [5:0] S_CHK1 = 6'd7;
    localparam logic [5:0] S_DDX  = 6'd8;
    localparam logic [5:0] S_DDY  = 6'd9;
    localparam logic [5:0] S_QD   = 6'd10;
    localparam logic [5:0] S_CHK2 = 6'd11;
    localparam logic [5:0] S_NUM1 = 6'd12;
    localparam logic [5:0] S_NUM2 = 6'd13;
    localparam logic [5:0] S_DA   = 6'd14;
    localparam logic [5:0] S_H1   = 6'd15;
    localparam logic [5:0] S_H2   = 6'd16;
    localparam logic [5:0] S_QH   = 6'd17;
    localparam logic [5:0] S_ADX  = 6'd18;
    localparam logic [5:0] S_DCX  = 6'd19;
    localparam logic [5:0] S_ADY  = 6'd20;
    localparam logic [5:0] S_DCY  = 6'd21;
    localparam logic [5:0] S_HDY  = 6'd22;
    localparam logic [5:0] S_DOX  = 6'd23;
    localparam logic [5:0] S_HDX  = 6'd24;
    localparam logic [5:0] S_DOY  = 6'd25;
    localparam logic [5:0] S_PTS  = 6'd26;
    localparam logic [5:0] S_E1X  = 6'd27;
    localparam logic [5:0] S_E1Y  = 6'd28;
    localparam logic [5:0] S_E2X  = 6'd29;
    localparam logic [5:0] S_E2Y  = 6'd30;
    localparam logic [5:0] S_SEL  = 6'd31;
    localparam logic [5:0] S_FIN  = 6'd32;

    function automatic logic [71:0] ext72(input logic [32:0] v);
        ext72 = {{39{v[32]}}, v};
    endfunction

    function automatic logic [35:0] ext36(input logic [32:0] v);
        ext36 = {{3{v[32]}}, v};
    endfunction

    function automatic logic [31:0] sat32(input logic [34:0] v);
        if (!v[34] && (v[33:31] != 3'b000))
        begin
            sat32 = 32'h7fff_ffff;
        end
        else if (v[34] && (v[33:31] != 3'b111))
        begin
            sat32 = 32'h8000_0000;
        end
        else
        begin
            sat32 = v[31:0];
        end
    endfunction

    logic [5:0]    state_reg;
    logic [5:0]    state_next;
    logic          pend_reg;
    logic          scan_done_reg;
    logic [CW-1:0] cnt_reg;
    logic [31:0]   qx_reg;
    logic [31:0]   qy_reg;
    logic [31:0]   qz_reg;
    logic          out_valid_reg;

    logic [31:0]   rx_reg;
    logic [31:0]   ry_reg;
    logic [31:0]   lx_reg;
    logic [31:0]   ly_reg;
    logic [30:0]   ab_reg;
    logic [CW-1:0] idx_reg;
    logic [71:0]   acc_reg;
    logic [71:0]   e1_reg;
    logic [35:0]   dr_reg;
    logic [35:0]   dl_reg;
    logic [35:0]   d_reg;
    logic [32:0]   a_reg;
    logic [31:0]   h_reg;
    logic [33:0]   cx_reg;
    logic [33:0]   cy_reg;
    logic [33:0]   ox_reg;
    logic [33:0]   oy_reg;
    logic [31:0]   p1x_reg;
    logic [31:0]   p1y_reg;
    logic [31:0]   p2x_reg;
    logic [31:0]   p2y_reg;
    logic [1:0]    act_reg;
    logic          snapped_reg;
    logic [31:0]   selx_reg;
    logic [31:0]   sely_reg;
    logic [1:0]    out_act_reg;
    logic          out_snapped_reg;
    logic [31:0]   out_x_reg;
    logic [31:0]   out_y_reg;
    logic [31:0]   out_z_reg;
    logic [9:0]    out_idx_reg;

    logic [30:0]   tol;
    alu_req_t      alu_req;
    alu_rsp_t      alu_rsp;
    logic          compute;
    logic          item_fire;
    logic          out_free;
    logic          eligible;
    logic [32:0]   dxr, dyr, dxl, dyl, ddx, ddy, e1x, e1y, e2x, e2y;
    logic [36:0]   s_sum;
    logic [38:0]   band_lo, band_hi, s39;
    logic          in_band;
    logic [38:0]   diff39, r0_39, adiff, d39;
    logic          meet;
    logic [CW+9:0] idx_wide;

    efs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .tol     (tol)
    );

    efs_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .rsp   (alu_rsp)
    );

    assign item.ready = (state_reg == S_IDLE);
    assign item_fire  = item.valid && item.ready;
    assign out_free   = !out_valid_reg || result.ready;
    assign eligible   = (cnt_reg < CNT_MAX) && !scan_done_reg && item.is_ellipse;

    assign dxr = {qx_reg[31], qx_reg} - {rx_reg[31], rx_reg};
    assign dyr = {qy_reg[31], qy_reg} - {ry_reg[31], ry_reg};
    assign dxl = {qx_reg[31], qx_reg} - {lx_reg[31], lx_reg};
    assign dyl = {qy_reg[31], qy_reg} - {ly_reg[31], ly_reg};
    assign ddx = {lx_reg[31], lx_reg} - {rx_reg[31], rx_reg};
    assign ddy = {ly_reg[31], ly_reg} - {ry_reg[31], ry_reg};
    assign e1x = {qx_reg[31], qx_reg} - {p1x_reg[31], p1x_reg};
    assign e1y = {qy_reg[31], qy_reg} - {p1y_reg[31], p1y_reg};
    assign e2x = {qx_reg[31], qx_reg} - {p2x_reg[31], p2x_reg};
    assign e2y = {qy_reg[31], qy_reg} - {p2y_reg[31], p2y_reg};

    // focal sum band, open at both edges
    assign s_sum   = {1'b0, dr_reg} + {1'b0, dl_reg};
    assign s39     = {2'b0, s_sum};
    assign band_lo = {8'b0, ab_reg} - {8'b0, tol};
    assign band_hi = {8'b0, ab_reg} + {8'b0, tol};
    assign in_band = ($signed(s39) > $signed(band_lo)) && ($signed(s39) < $signed(band_hi));

    // circles meet unless apart, nested or coincident
    assign r0_39  = {8'b0, ab_reg} - {3'b0, dl_reg};
    assign diff39 = {8'b0, ab_reg} - {2'b0, dl_reg, 1'b0};
    assign adiff  = diff39[38] ? 39'(-diff39) : diff39;
    assign d39    = {3'b0, d_reg};
    assign meet   = !(d39 > {8'b0, ab_reg}) && !(d39 < adiff)
                    && !((d_reg == '0) && (diff39 == '0));

    assign idx_wide = {10'b0, idx_reg};

    always_comb
    begin
        compute   = 1'b1;
        alu_req.op = ALU_MUL;
        alu_req.a  = '0;
        alu_req.b  = '0;
        case (state_reg)
            S_DRX: begin alu_req.a = ext72(dxr); alu_req.b = ext36(dxr); end
            S_DRY: begin alu_req.a = ext72(dyr); alu_req.b = ext36(dyr); end
            S_DLX: begin alu_req.a = ext72(dxl); alu_req.b = ext36(dxl); end
            S_DLY: begin alu_req.a = ext72(dyl); alu_req.b = ext36(dyl); end
            S_DDX: begin alu_req.a = ext72(ddx); alu_req.b = ext36(ddx); end
            S_DDY: begin alu_req.a = ext72(ddy); alu_req.b = ext36(ddy); end
            S_QDR, S_QDL, S_QD:
            begin
                alu_req.op = ALU_SQRT;
                alu_req.a  = acc_reg;
            end
            S_NUM1:
            begin
                alu_req.a = {{33{diff39[38]}}, diff39};
                alu_req.b = {5'b0, ab_reg};
            end
            S_NUM2:
            begin
                alu_req.a = {36'b0, d_reg};
                alu_req.b = d_reg;
            end
            S_DA:
            begin
                alu_req.op = ALU_DIV;
                alu_req.a  = acc_reg;
                alu_req.b  = {d_reg[34:0], 1'b0};
            end
            S_H1:
            begin
                alu_req.a = {{33{r0_39[38]}}, r0_39};
                alu_req.b = r0_39[35:0];
            end
            S_H2: begin alu_req.a = ext72(a_reg); alu_req.b = ext36(a_reg); end
            S_QH:
            begin
                alu_req.op = ALU_SQRT;
                alu_req.a  = acc_reg[71] ? '0 : acc_reg;
            end
            S_ADX: begin alu_req.a = ext72(a_reg); alu_req.b = ext36(ddx); end
            S_ADY: begin alu_req.a = ext72(a_reg); alu_req.b = ext36(ddy); end
            S_HDY: begin alu_req.a = {40'b0, h_reg}; alu_req.b = ext36(ddy); end
            S_HDX: begin alu_req.a = {40'b0, h_reg}; alu_req.b = ext36(ddx); end
            S_DCX, S_DCY, S_DOX, S_DOY:
            begin
                alu_req.op = ALU_DIV;
                alu_req.a  = acc_reg;
                alu_req.b  = d_reg;
            end
            S_E1X: begin alu_req.a = ext72(e1x); alu_req.b = ext36(e1x); end
            S_E1Y: begin alu_req.a = ext72(e1y); alu_req.b = ext36(e1y); end
            S_E2X: begin alu_req.a = ext72(e2x); alu_req.b = ext36(e2x); end
            S_E2Y: begin alu_req.a = ext72(e2y); alu_req.b = ext36(e2y); end
            default: compute = 1'b0;
        endcase
        alu_req.start = compute && !pend_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_fire && item.kind == KIND_ENTITY)
                begin
                    state_next = eligible ? S_DRX : S_FIN;
                end
            end
            S_DRX:  if (alu_rsp.done) state_next = S_DRY;
            S_DRY:  if (alu_rsp.done) state_next = S_QDR;
            S_QDR:  if (alu_rsp.done) state_next = S_DLX;
            S_DLX:  if (alu_rsp.done) state_next = S_DLY;
            S_DLY:  if (alu_rsp.done) state_next = S_QDL;
            S_QDL:  if (alu_rsp.done) state_next = S_CHK1;
            S_CHK1: state_next = in_band ? S_DDX : S_FIN;
            S_DDX:  if (alu_rsp.done) state_next = S_DDY;
            S_DDY:  if (alu_rsp.done) state_next = S_QD;
            S_QD:   if (alu_rsp.done) state_next = S_CHK2;
            S_CHK2: state_next = meet ? S_NUM1 : S_FIN;
            S_NUM1: if (alu_rsp.done) state_next = S_NUM2;
            S_NUM2: if (alu_rsp.done) state_next = S_DA;
            S_DA:   if (alu_rsp.done) state_next = S_H1;
            S_H1:   if (alu_rsp.done) state_next = S_H2;
            S_H2:   if (alu_rsp.done) state_next = S_QH;
            S_QH:   if (alu_rsp.done) state_next = S_ADX;
            S_ADX:  if (alu_rsp.done) state_next = S_DCX;
            S_DCX:  if (alu_rsp.done) state_next = S_ADY;
            S_ADY:  if (alu_rsp.done) state_next = S_DCY;
            S_DCY:  if (alu_rsp.done) state_next = S_HDY;
            S_HDY:  if (alu_rsp.done) state_next = S_DOX;
            S_DOX:  if (alu_rsp.done) state_next = S_HDX;
            S_HDX:  if (alu_rsp.done) state_next = S_DOY;
            S_DOY:  if (alu_rsp.done) state_next = S_PTS;
            S_PTS:  state_next = S_E1X;
            S_E1X:  if (alu_rsp.done) state_next = S_E1Y;
            S_E1Y:  if (alu_rsp.done) state_next = S_E2X;
            S_E2X:  if (alu_rsp.done) state_next = S_E2Y;
            S_E2Y:  if (alu_rsp.done) state_next = S_SEL;
            S_SEL:  state_next = S_FIN;
            S_FIN:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            scan_done_reg <= 1'b0;
            cnt_reg       <= '0;
            qx_reg        <= '0;
            qy_reg        <= '0;
            qz_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (alu_req.start)
            begin
                pend_reg <= 1'b1;
            end
            else if (alu_rsp.done)
            begin
                pend_reg <= 1'b0;
            end
            if (item_fire)
            begin
                if (item.kind == KIND_QUERY)
                begin
                    qx_reg        <= item.pointer_x;
                    qy_reg        <= item.pointer_y;
                    qz_reg        <= item.pointer_z;
                    scan_done_reg <= 1'b0;
                    cnt_reg       <= '0;
                end
                else if (cnt_reg < CNT_MAX)
                begin
                    cnt_reg <= cnt_reg + CW'(1);
                end
            end
            if (state_reg == S_SEL)
            begin
                scan_done_reg <= 1'b1;
            end
            if (state_reg == S_FIN && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            rx_reg      <= item.right_focus_x;
            ry_reg      <= item.right_focus_y;
            lx_reg      <= item.left_focus_x;
            ly_reg      <= item.left_focus_y;
            ab_reg      <= item.focal_sum;
            idx_reg     <= cnt_reg;
            act_reg     <= ACT_LEAVE;
            snapped_reg <= 1'b0;
        end
        if (alu_rsp.done)
        begin
            case (state_reg) inside
                S_DRX, S_DLX, S_DDX, S_NUM1, S_H1, S_ADX, S_ADY, S_HDY, S_HDX,
                S_E1X, S_E2X:
                    acc_reg <= alu_rsp.res;
                S_DRY, S_DLY, S_DDY, S_NUM2, S_E2Y:
                    acc_reg <= acc_reg + alu_rsp.res;
                S_E1Y:  e1_reg  <= acc_reg + alu_rsp.res;
                S_H2:   acc_reg <= acc_reg - alu_rsp.res;
                S_QDR:  dr_reg  <= alu_rsp.res[35:0];
                S_QDL:  dl_reg  <= alu_rsp.res[35:0];
                S_QD:   d_reg   <= alu_rsp.res[35:0];
                S_DA:   a_reg   <= alu_rsp.res[32:0];
                S_QH:   h_reg   <= alu_rsp.res[31:0];
                S_DCX:  cx_reg  <= {{2{rx_reg[31]}}, rx_reg} + alu_rsp.res[33:0];
                S_DCY:  cy_reg  <= {{2{ry_reg[31]}}, ry_reg} + alu_rsp.res[33:0];
                S_DOX:  ox_reg  <= alu_rsp.res[33:0];
                S_DOY:  oy_reg  <= alu_rsp.res[33:0];
                default: ;
            endcase
        end
        if (state_reg == S_CHK1)
        begin
            act_reg <= in_band ? ACT_SET : ACT_CLEAR;
        end
        if (state_reg == S_PTS)
        begin
            p1x_reg <= sat32({cx_reg[33], cx_reg} + {ox_reg[33], ox_reg});
            p1y_reg <= sat32({cy_reg[33], cy_reg} - {oy_reg[33], oy_reg});
            p2x_reg <= sat32({cx_reg[33], cx_reg} - {ox_reg[33], ox_reg});
            p2y_reg <= sat32({cy_reg[33], cy_reg} + {oy_reg[33], oy_reg});
        end
        // second point wins a tie
        if (state_reg == S_SEL)
        begin
            snapped_reg <= 1'b1;
            selx_reg    <= (e1_reg < acc_reg) ? p1x_reg : p2x_reg;
            sely_reg    <= (e1_reg < acc_reg) ? p1y_reg : p2y_reg;
        end
        if (state_reg == S_FIN && out_free)
        begin
            out_act_reg     <= act_reg;
            out_snapped_reg <= snapped_reg;
            out_x_reg       <= snapped_reg ? selx_reg : '0;
            out_y_reg       <= snapped_reg ? sely_reg : '0;
            out_z_reg       <= snapped_reg ? qz_reg : '0;
            out_idx_reg     <= idx_wide[9:0];
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.highlight_action = out_act_reg;
    assign result.snapped          = out_snapped_reg;
    assign result.snap_x           = out_x_reg;
    assign result.snap_y           = out_y_reg;
    assign result.snap_z           = out_z_reg;
    assign result.entity_index     = out_idx_reg;

endmodule

`default_nettype wire

// ===== sv/efs_checker.sv =====
`default_nettype none

module efs_checker
    import efs_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic [1:0]  act,
    input wire logic        snapped,
    input wire logic [31:0] sx,
    input wire logic [31:0] sy,
    input wire logic [31:0] sz,
    input wire logic [9:0]  idx
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(act) && $stable(snapped)
            && $stable(sx) && $stable(sy) && $stable(sz) && $stable(idx))
        else $error("result word changed under stall");

    a_act_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> act == ACT_LEAVE || act == ACT_CLEAR || act == ACT_SET)
        else $error("highlight action out of range");

    a_snap_set: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && snapped |-> act == ACT_SET)
        else $error("snap without highlight");

    a_no_snap_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !snapped |-> sx == '0 && sy == '0 && sz == '0)
        else $error("snap point not zero without snap");

endmodule

bind ellipse_focal_snap efs_checker u_efs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .act       (result.highlight_action),
    .snapped   (result.snapped),
    .sx        (result.snap_x),
    .sy        (result.snap_y),
    .sz        (result.snap_z),
    .idx       (result.entity_index)
);

`default_nettype wire
